// ----- hdl/lc2k_pkg.sv -----
package lc2k_pkg;

  localparam int MEM_WORDS = 65536;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int NUM_REGS  = 8;
  localparam int REG_W     = $clog2(NUM_REGS);
  localparam int WORD_W    = 32;
  localparam int PC_OUT_W  = 16;
  localparam int OFF_W     = 16;

  localparam int OPC_LSB = 22;
  localparam int RA_LSB  = 19;
  localparam int RB_LSB  = 16;
  localparam int RD_LSB  = 0;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } opcode_t;

  typedef struct packed {
    logic                     command;
    logic [15:0]              load_address;
    logic signed [WORD_W-1:0] load_data;
  } in_word_t;

  typedef struct packed {
    logic [PC_OUT_W-1:0]      program_counter;
    logic                     halted;
    logic [WORD_W-1:0]        executed_count;
    logic [2:0]               executed_opcode;
    logic                     reg_write_valid;
    logic [REG_W-1:0]         reg_write_index;
    logic signed [WORD_W-1:0] reg_write_value;
    logic                     mem_write_valid;
    logic [PC_OUT_W-1:0]      mem_write_address;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NOCHG,
    ST_DECODE,
    ST_EXEC,
    ST_LWB
  } state_t;

  typedef enum logic [1:0] {
    CM_NONE,
    CM_NOCHANGE,
    CM_EXEC,
    CM_LW
  } commit_t;

  typedef struct packed {
    logic    fetch;
    logic    mem_wr_load;
    logic    ir_load;
    logic    rf_read;
    logic    ea_read;
    commit_t commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic halted;
    logic is_lw;
  } ctrl_sts_t;

endpackage

// ----- hdl/lc2k_ctrl.sv -----
module lc2k_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic                item_command,
  input  lc2k_pkg::ctrl_sts_t sts,
  output lc2k_pkg::ctrl_cmd_t cmd
);
  import lc2k_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    item_ready      = 1'b0;
    cmd.fetch       = 1'b0;
    cmd.mem_wr_load = 1'b0;
    cmd.ir_load     = 1'b0;
    cmd.rf_read     = 1'b0;
    cmd.ea_read     = 1'b0;
    cmd.commit      = CM_NONE;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item_command == CMD_LOAD) begin
            cmd.mem_wr_load = 1'b1;
            state_next      = ST_NOCHG;
          end else if (sts.halted) begin
            state_next = ST_NOCHG;
          end else begin
            cmd.fetch  = 1'b1;
            state_next = ST_DECODE;
          end
        end
      end
      ST_NOCHG: begin
        if (sts.out_free) begin
          cmd.commit = CM_NOCHANGE;
          state_next = ST_IDLE;
        end
      end
      ST_DECODE: begin
        cmd.ir_load = 1'b1;
        cmd.rf_read = 1'b1;
        state_next  = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.is_lw) begin
          cmd.ea_read = 1'b1;
          state_next  = ST_LWB;
        end else if (sts.out_free) begin
          cmd.commit = CM_EXEC;
          state_next = ST_IDLE;
        end
      end
      ST_LWB: begin
        if (sts.out_free) begin
          cmd.commit = CM_LW;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A halted machine must never fetch again.
  a_no_fetch_halted: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |-> !sts.halted)
    else $error("fetch issued while halted");

  // The memory port carries at most one access per cycle from the sequencer.
  a_one_mem_op: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.fetch, cmd.mem_wr_load, cmd.ea_read}) <= 1)
    else $error("conflicting memory commands");

endmodule

// ----- hdl/lc2k_datapath.sv -----
module lc2k_datapath (
  input  logic                clk,
  input  logic                rst,
  input  lc2k_pkg::in_word_t  item,
  input  lc2k_pkg::ctrl_cmd_t cmd,
  output lc2k_pkg::ctrl_sts_t sts,
  output lc2k_pkg::out_word_t result,
  output logic                result_valid,
  input  logic                result_ready
);
  import lc2k_pkg::*;

  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] rf [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld;

  logic [ADDR_W-1:0] pc, pc_inc, pc_new, ea, br_target, mem_waddr, mem_raddr;
  logic              halted, halt_new;
  logic [WORD_W-1:0] cnt, cnt_inc;
  logic [WORD_W-1:0] ir;

  logic [WORD_W-1:0] ra_raw, rb_raw, ra_val, rb_val;
  logic              ra_vld, rb_vld;

  opcode_t           opc;
  logic [REG_W-1:0]  ra_idx, rb_idx, rd_idx;
  logic [OFF_W-1:0]  off;

  logic              rw_en, mw_en, mem_we, mem_re;
  logic [REG_W-1:0]  rw_idx;
  logic [WORD_W-1:0] rw_val, mem_wdata;
  logic              out_free, arch_commit;

  assign opc    = opcode_t'(ir[OPC_LSB +: 3]);
  assign ra_idx = ir[RA_LSB +: REG_W];
  assign rb_idx = ir[RB_LSB +: REG_W];
  assign rd_idx = ir[RD_LSB +: REG_W];
  assign off    = ir[OFF_W-1:0];

  assign ra_val = ra_vld ? ra_raw : '0;
  assign rb_val = rb_vld ? rb_raw : '0;

  // The offset is added at address width; only the low address bits survive the wrap, so no sign extension is needed.
  assign pc_inc    = pc + ADDR_W'(1);
  assign ea        = ra_val[ADDR_W-1:0] + off[ADDR_W-1:0];
  assign br_target = pc_inc + off[ADDR_W-1:0];
  assign cnt_inc   = cnt + WORD_W'(1);

  assign out_free    = !result_valid || result_ready;
  assign arch_commit = (cmd.commit == CM_EXEC) || (cmd.commit == CM_LW);

  assign sts.out_free = out_free;
  assign sts.halted   = halted;
  assign sts.is_lw    = (opc == OP_LW);

  always_comb begin
    rw_en    = 1'b0;
    rw_idx   = '0;
    rw_val   = '0;
    mw_en    = 1'b0;
    pc_new   = pc_inc;
    halt_new = halted;
    if (cmd.commit == CM_EXEC) begin
      unique case (opc)
        OP_ADD: begin
          rw_en  = 1'b1;
          rw_idx = rd_idx;
          rw_val = ra_val + rb_val;
        end
        OP_NOR: begin
          rw_en  = 1'b1;
          rw_idx = rd_idx;
          rw_val = ~(ra_val | rb_val);
        end
        OP_SW: begin
          mw_en = 1'b1;
        end
        OP_BEQ: begin
          if (ra_val == rb_val) begin
            pc_new = br_target;
          end
        end
        OP_JALR: begin
          rw_en  = 1'b1;
          rw_idx = rb_idx;
          rw_val = WORD_W'(pc) + WORD_W'(1);
          if (ra_idx != rb_idx) begin
            pc_new = ra_val[ADDR_W-1:0];
          end
        end
        OP_HALT: begin
          halt_new = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (cmd.commit == CM_LW) begin
      rw_en  = 1'b1;
      rw_idx = rb_idx;
      rw_val = rdata;
    end
  end

  assign mem_we    = cmd.mem_wr_load || mw_en;
  assign mem_waddr = cmd.mem_wr_load ? item.load_address[ADDR_W-1:0] : ea;
  assign mem_wdata = cmd.mem_wr_load ? item.load_data : rb_val;
  assign mem_re    = cmd.fetch || cmd.ea_read;
  assign mem_raddr = cmd.fetch ? pc : ea;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rw_en) begin
      rf[rw_idx] <= rw_val;
    end
    if (cmd.rf_read) begin
      ra_raw <= rf[rdata[RA_LSB +: REG_W]];
      rb_raw <= rf[rdata[RB_LSB +: REG_W]];
      ra_vld <= rf_vld[rdata[RA_LSB +: REG_W]];
      rb_vld <= rf_vld[rdata[RB_LSB +: REG_W]];
    end
    if (cmd.ir_load) begin
      ir <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= '0;
      halted       <= 1'b0;
      cnt          <= '0;
      rf_vld       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (arch_commit) begin
        pc     <= pc_new;
        halted <= halt_new;
        cnt    <= cnt_inc;
      end
      if (rw_en) begin
        rf_vld[rw_idx] <= 1'b1;
      end
      if (cmd.commit != CM_NONE) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit != CM_NONE) begin
      result.program_counter   <= arch_commit ? PC_OUT_W'(pc_new) : PC_OUT_W'(pc);
      result.halted            <= arch_commit ? halt_new : halted;
      result.executed_count    <= arch_commit ? cnt_inc : cnt;
      result.executed_opcode   <= arch_commit ? opc : '0;
      result.reg_write_valid   <= rw_en;
      result.reg_write_index   <= rw_idx;
      result.reg_write_value   <= rw_val;
      result.mem_write_valid   <= mw_en;
      result.mem_write_address <= mw_en ? PC_OUT_W'(ea) : '0;
    end
  end

  // A new result may only be written into a free output register.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit != CM_NONE) |-> out_free)
    else $error("result overwritten before it was taken");

  // Only a halt can stop the machine, and nothing but reset restarts it.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted flag cleared");

  // Load words and halted steps leave pc and count untouched.
  a_nochg_state: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit == CM_NOCHANGE) |=> (cnt == $past(cnt)) && (pc == $past(pc)))
    else $error("state changed by a non-executing word");

endmodule

// ----- hdl/lc2k_instruction_executor.sv -----
// Channel  Signals                              Direction  Word
// item     item_valid, item_ready, item         in         in_word_t (command, load address/data)
// result   result_valid, result_ready, result   out        out_word_t (pc, halt, count, writes)
//
// One word is in flight at a time; a new word is taken while a result waits in the output register.
// A step goes through fetch, register file read and execute, and a lw step adds a data read
// before write-back, since the data read shares the single memory port with the instruction fetch.
// A step taken while halted changes nothing.
// Reset clears pc, halt flag, count and register file; memory contents are undefined until written.
// A stalled result holds the sequencer in its last state until the output register frees up.
module lc2k_instruction_executor (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  lc2k_pkg::in_word_t item,
  output logic               result_valid,
  input  logic               result_ready,
  output lc2k_pkg::out_word_t result
);
  import lc2k_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lc2k_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_command (item.command),
    .sts          (sts),
    .cmd          (cmd)
  );

  lc2k_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import lc2k_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_word_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_word_t result;

  lc2k_instruction_executor u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow machine state, advanced as each word is planned.
  logic [WORD_W-1:0] image [MEM_WORDS];
  bit                written [MEM_WORDS];
  int unsigned       loaded_addrs [$];
  logic [WORD_W-1:0] gpr [NUM_REGS];
  logic [ADDR_W-1:0] pc_q = '0;
  logic              halted_q = 1'b0;
  logic [WORD_W-1:0] count_q = '0;
  int                op_hits [8];

  in_word_t  program_feed [$];
  out_word_t pending_outcomes [$];
  out_word_t awaited_outcomes [$];
  out_word_t driven_outcome;

  int   loads_planned = 0;
  int   steps_planned = 0;
  int   words_planned = 0;
  int   words_accepted = 0;
  int   results_checked = 0;
  int   failures = 0;
  logic word_taken = 1'b0;
  logic result_taken = 1'b0;
  int   send_gap = 0;
  int   send_calm = 0;
  int   recv_gap = 0;
  int   recv_calm = 0;
  int unsigned cycle_count = 0;

  function automatic void store_word(logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] data);
    if (!written[addr]) loaded_addrs.push_back(32'(addr));
    written[addr] = 1'b1;
    image[addr] = data;
  endfunction

  function automatic out_word_t execute_word(in_word_t w);
    out_word_t         r;
    logic [WORD_W-1:0] code;
    logic [WORD_W-1:0] a_val;
    logic [WORD_W-1:0] b_val;
    logic [WORD_W-1:0] offset;
    logic [ADDR_W-1:0] ea;
    logic [ADDR_W-1:0] next_pc;
    opcode_t           op;
    r = '0;
    if (w.command == CMD_LOAD) begin
      store_word(ADDR_W'(w.load_address), w.load_data);
    end else if (!halted_q) begin
      code = image[pc_q];
      op = opcode_t'(code[OPC_LSB +: 3]);
      a_val = gpr[code[RA_LSB +: 3]];
      b_val = gpr[code[RB_LSB +: 3]];
      offset = {{(WORD_W - OFF_W){code[OFF_W-1]}}, code[OFF_W-1:0]};
      ea = ADDR_W'(a_val + offset);
      next_pc = pc_q + ADDR_W'(1);
      count_q = count_q + 1;
      op_hits[op]++;
      r.executed_opcode = op;
      case (op)
        OP_ADD, OP_NOR: begin
          r.reg_write_valid = 1'b1;
          r.reg_write_index = code[RD_LSB +: 3];
          r.reg_write_value = (op == OP_ADD) ? a_val + b_val : ~(a_val | b_val);
        end
        OP_LW: begin
          r.reg_write_valid = 1'b1;
          r.reg_write_index = code[RB_LSB +: 3];
          r.reg_write_value = image[ea];
        end
        OP_SW: begin
          store_word(ea, b_val);
          r.mem_write_valid = 1'b1;
          r.mem_write_address = PC_OUT_W'(ea);
        end
        OP_BEQ: begin
          if (a_val == b_val) next_pc = ADDR_W'(32'(pc_q) + 32'd1 + offset);
        end
        OP_JALR: begin
          r.reg_write_valid = 1'b1;
          r.reg_write_index = code[RB_LSB +: 3];
          r.reg_write_value = 32'(pc_q) + 32'd1;
          if (code[RA_LSB +: 3] != code[RB_LSB +: 3]) next_pc = ADDR_W'(a_val);
        end
        OP_HALT: begin
          halted_q = 1'b1;
        end
        default: begin
        end
      endcase
      if (r.reg_write_valid) gpr[r.reg_write_index] = r.reg_write_value;
      pc_q = next_pc;
    end
    r.program_counter = PC_OUT_W'(pc_q);
    r.halted = halted_q;
    r.executed_count = count_q;
    return r;
  endfunction

  function automatic void queue_word(logic cmd, logic [15:0] addr, logic [WORD_W-1:0] data);
    in_word_t w;
    w.command = cmd;
    w.load_address = addr;
    w.load_data = data;
    program_feed.push_back(w);
    pending_outcomes.push_back(execute_word(w));
    if (cmd == CMD_LOAD) loads_planned++;
    else steps_planned++;
  endfunction

  function automatic logic [WORD_W-1:0] make_inst(opcode_t op, int ra, int rb,
                                                  logic [15:0] low);
    return {7'($urandom), op, 3'(ra), 3'(rb), low};
  endfunction

  // Places an instruction at the current pc and executes it.
  function automatic void run_inst(logic [WORD_W-1:0] code);
    queue_word(CMD_LOAD, 16'(pc_q), code);
    queue_word(CMD_STEP, 16'($urandom), $urandom);
  endfunction

  function automatic logic [WORD_W-1:0] random_inst();
    int          pick;
    int          ra;
    int          rb;
    logic [15:0] low;
    opcode_t     op;
    pick = $urandom_range(0, 99);
    ra = $urandom_range(0, 7);
    rb = $urandom_range(0, 7);
    low = 16'($urandom);
    if (pick < 18) op = OP_ADD;
    else if (pick < 32) op = OP_NOR;
    else if (pick < 48) begin
      op = OP_LW;
      low = 16'(loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)] - gpr[ra]);
    end else if (pick < 62) op = OP_SW;
    else if (pick < 78) begin
      op = OP_BEQ;
      if ($urandom_range(0, 3) != 0) low = 16'($urandom_range(0, 12)) - 16'd6;
    end else if (pick < 88) op = OP_JALR;
    else op = OP_NOOP;
    return make_inst(op, ra, rb, low);
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || word_taken) begin
      if (send_gap != 0) begin
        item_valid <= 1'b0;
        send_gap--;
      end else if (program_feed.size() != 0) begin
        item <= program_feed.pop_front();
        driven_outcome <= pending_outcomes.pop_front();
        item_valid <= 1'b1;
        if (send_calm != 0) begin
          send_calm--;
        end else begin
          send_gap = pick_idle();
          if ($urandom_range(0, 99) == 0) send_calm = 40;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_taken) begin
        if (recv_calm != 0) begin
          recv_calm--;
        end else begin
          recv_gap = pick_idle();
          if ($urandom_range(0, 99) == 0) recv_calm = 40;
        end
      end
      if (recv_gap != 0) begin
        result_ready <= 1'b0;
        recv_gap--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    word_taken <= !rst && item_valid && item_ready;
    result_taken <= !rst && result_valid && result_ready;
    if (!rst && result_valid && result_ready) begin
      if (awaited_outcomes.size() == 0) begin
        $error("result word with nothing expected: pc 0x%0h", result.program_counter);
        failures++;
      end else begin
        want = awaited_outcomes.pop_front();
        check_field("program_counter", 32'(want.program_counter),
                    32'(result.program_counter));
        check_field("halted", 32'(want.halted), 32'(result.halted));
        check_field("executed_count", want.executed_count, result.executed_count);
        check_field("executed_opcode", 32'(want.executed_opcode),
                    32'(result.executed_opcode));
        check_field("reg_write_valid", 32'(want.reg_write_valid),
                    32'(result.reg_write_valid));
        check_field("reg_write_index", 32'(want.reg_write_index),
                    32'(result.reg_write_index));
        check_field("reg_write_value", want.reg_write_value, result.reg_write_value);
        check_field("mem_write_valid", 32'(want.mem_write_valid),
                    32'(result.mem_write_valid));
        check_field("mem_write_address", 32'(want.mem_write_address),
                    32'(result.mem_write_address));
        results_checked++;
      end
    end
    if (!rst && item_valid && item_ready) begin
      awaited_outcomes.push_back(driven_outcome);
      words_accepted++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, awaited_outcomes.size());
      $display("lc2k_instruction_executor regression: fail");
      $finish;
    end
  end

  initial begin
    int                pick;
    logic [WORD_W-1:0] code;
    opcode_t           cur_op;
    logic [ADDR_W-1:0] ea;
    for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;

    // Directed program: extreme data, address wrap both ways, register zero
    // written, branches both ways, jalr with and without the same register,
    // and a jalr at the top of memory whose link value exceeds 16 bits.
    queue_word(CMD_LOAD, 16'hFFFF, 32'hFFFF_FFFF);
    queue_word(CMD_LOAD, 16'h8000, 32'h8000_0000);
    queue_word(CMD_LOAD, 16'h7FFF, 32'h7FFF_FFFF);
    run_inst(make_inst(OP_LW, 0, 1, 16'hFFFF));
    run_inst(make_inst(OP_LW, 0, 2, 16'h8000));
    run_inst(make_inst(OP_LW, 0, 3, 16'h7FFF));
    run_inst(make_inst(OP_ADD, 1, 1, 16'h0005));
    run_inst(make_inst(OP_ADD, 2, 3, 16'h0000));
    run_inst(make_inst(OP_NOR, 1, 3, 16'h0006));
    run_inst(make_inst(OP_SW, 1, 3, 16'h0100));
    run_inst(make_inst(OP_BEQ, 6, 1, 16'hFFF0));
    run_inst(make_inst(OP_BEQ, 0, 1, 16'hFFFB));
    run_inst(make_inst(OP_JALR, 1, 7, 16'h0000));
    run_inst(make_inst(OP_JALR, 2, 2, 16'h0000));
    run_inst(make_inst(OP_NOOP, 5, 4, 16'hFFFF));

    // Random execution. A fetch is never allowed to hit an unwritten word,
    // a halt or a load from an unwritten address; such a word is replaced
    // by a fresh instruction first. Otherwise existing code is often rerun.
    while (program_feed.size() < 790) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_word(CMD_LOAD, 16'($urandom), $urandom);
      end else if (pick < 13) begin
        queue_word(CMD_LOAD, 16'(pc_q), $urandom);
      end else begin
        code = image[pc_q];
        cur_op = opcode_t'(code[OPC_LSB +: 3]);
        ea = ADDR_W'(gpr[code[RA_LSB +: 3]] + {{(WORD_W - OFF_W){code[OFF_W-1]}},
                                                 code[OFF_W-1:0]});
        if (!written[pc_q] || cur_op == OP_HALT || (cur_op == OP_LW && !written[ea]) ||
            pick < 50) begin
          run_inst(random_inst());
        end else begin
          queue_word(CMD_STEP, 16'($urandom), $urandom);
        end
      end
    end

    // Halt, then steps and loads against the halted machine.
    run_inst(make_inst(OP_HALT, $urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom)));
    repeat (4) begin
      queue_word(CMD_STEP, 16'($urandom), $urandom);
      queue_word(CMD_LOAD, 16'(pc_q), $urandom);
      queue_word(CMD_LOAD, 16'($urandom), $urandom);
    end
    queue_word(CMD_STEP, 16'($urandom), $urandom);
    words_planned = program_feed.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_accepted != words_planned || awaited_outcomes.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d loads, %0d steps) and checked %0d results in %0d cycles.",
             words_planned, loads_planned, steps_planned, results_checked, cycle_count);
    $display("Executed add %0d, nor %0d, lw %0d, sw %0d, beq %0d, jalr %0d, halt %0d, noop %0d.",
             op_hits[OP_ADD], op_hits[OP_NOR], op_hits[OP_LW], op_hits[OP_SW],
             op_hits[OP_BEQ], op_hits[OP_JALR], op_hits[OP_HALT], op_hits[OP_NOOP]);
    if (failures == 0) begin
      $display("lc2k_instruction_executor regression: pass");
    end else begin
      $display("lc2k_instruction_executor regression: fail");
    end
    $finish;
  end

endmodule
